FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define CCSD_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("ccsd assertion failed");
// next-cycle implication
`define CCSD_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("ccsd assertion failed");
`else
`define CCSD_ASSERT_IMP(label, clk, rst_n, pre, post)
`define CCSD_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

FILE: sv/ccsd_pkg.sv
// Shared constants and types of the crank/cam speed decoder
`timescale 1ns / 1ps
package ccsd_pkg;

  localparam int CURVE_DEPTH = 24;
  localparam int CURVE_AW    = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;

  localparam int SPEED_W = 20;
  localparam int IVL_W   = 16;
  localparam int HALF_W  = 8;
  localparam int POS_W   = 16;
  localparam int CNT_W   = 8;
  localparam int IDX_W   = 5;
  localparam int CFG_IW  = 8;
  localparam int CFG_DW  = 20;

  localparam logic [SPEED_W-1:0] NUMERATOR_RST = SPEED_W'(312500);
  localparam logic [SPEED_W-1:0] THRESHOLD_RST = SPEED_W'(600);
  localparam logic [CNT_W-1:0]   SYNC_CNT_RST  = CNT_W'(12);
  localparam logic [HALF_W-1:0]  STALL_RST     = HALF_W'(8'hF4);

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CRANK = 2'd1,
    OP_CAM   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_CRANK = 2'd1,
    MODE_RUN   = 2'd2
  } mode_e;

  localparam logic [CFG_IW-1:0] REG_NUMERATOR = CFG_IW'(0);
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = CFG_IW'(1);
  localparam logic [CFG_IW-1:0] REG_SYNC_CNT  = CFG_IW'(2);
  localparam logic [CFG_IW-1:0] REG_STALL     = CFG_IW'(3);

  localparam int DIV_STEPS = SPEED_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

endpackage

FILE: sv/ccsd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
`timescale 1ns / 1ps
module ccsd_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ccsd_pkg::SPEED_W-1:0]  dividend_i,
  input  logic [ccsd_pkg::IVL_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic                          done_o,
  output logic [ccsd_pkg::SPEED_W-1:0]  quotient_o
);

  logic                          busy_q, done_q;
  logic [ccsd_pkg::DIV_CW-1:0]   cnt_q;
  logic [ccsd_pkg::SPEED_W-1:0]  dq_q;
  logic [ccsd_pkg::IVL_W-1:0]    rem_q;
  logic [ccsd_pkg::IVL_W-1:0]    dvs_q;

  logic [ccsd_pkg::IVL_W:0]   rem_shift;
  logic [ccsd_pkg::IVL_W-1:0] rem_d;
  logic                       fits;

  // the remainder stays below the divisor, so it always fits in IVL_W bits
  always_comb begin
    rem_shift = {rem_q, dq_q[ccsd_pkg::SPEED_W-1]};
    fits      = rem_shift >= {1'b0, dvs_q};
    rem_d     = fits ? ccsd_pkg::IVL_W'(rem_shift - {1'b0, dvs_q})
                     : rem_shift[ccsd_pkg::IVL_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= ccsd_pkg::DIV_CW'(ccsd_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ccsd_pkg::DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift dividend out at the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[ccsd_pkg::SPEED_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

FILE: sv/ccsd_curve.sv
// Interval curve memory with per-entry valid bits cleared at reset
`timescale 1ns / 1ps
module ccsd_curve (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [ccsd_pkg::CURVE_AW-1:0] wr_addr_i,
  input  logic [ccsd_pkg::IVL_W-1:0]    wr_data_i,
  input  logic [ccsd_pkg::CURVE_AW-1:0] rd_addr_i,
  output logic [ccsd_pkg::IVL_W-1:0]    rd_data_o
);

  logic [ccsd_pkg::IVL_W-1:0]       mem [ccsd_pkg::CURVE_DEPTH];
  logic [ccsd_pkg::CURVE_DEPTH-1:0] valid_q;
  logic [ccsd_pkg::IVL_W-1:0]       rd_data_q;
  logic                             rd_valid_q;
  logic                             rd_ok;

  assign rd_ok = (ccsd_pkg::CURVE_AW + 1)'(rd_addr_i) <
                 (ccsd_pkg::CURVE_AW + 1)'(ccsd_pkg::CURVE_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      rd_valid_q <= rd_ok && valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_ok) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: sv/crank_cam_speed_decoder.sv
// Top level of the crank/cam speed decoder
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_ready_o    op_i, curve_index_i
//  out      source     out_valid_o / out_ready_i  speed_o, run_mode_o,
//                                                 overrun_error_o, curve_value_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Tick, cam and read transactions go through EXEC and DONE from accept to result register.
// A crank transaction also waits in DIV between them while the bit-serial divider runs.
// One transaction is processed at a time; the result register lets the next
// transaction be accepted while the previous result waits on out_ready_i.
// Reset clears all state at once; the curve uses valid bits, so no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module crank_cam_speed_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        op_i,
  input  logic [ccsd_pkg::IDX_W-1:0]        curve_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ccsd_pkg::SPEED_W-1:0]      speed_o,
  output logic [1:0]                        run_mode_o,
  output logic                              overrun_error_o,
  output logic [ccsd_pkg::IVL_W-1:0]        curve_value_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ccsd_pkg::CFG_IW-1:0]       cfg_index_i,
  input  logic [ccsd_pkg::CFG_DW-1:0]       cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e                          state_q;
  ccsd_pkg::op_e                   op_q;
  logic [ccsd_pkg::IDX_W-1:0]      idx_q;
  logic                            rd_hit_q;

  logic [ccsd_pkg::SPEED_W-1:0]    numerator_q, threshold_q;
  logic [ccsd_pkg::CNT_W-1:0]      sync_cnt_q;
  logic [ccsd_pkg::HALF_W-1:0]     stall_q;

  logic [ccsd_pkg::HALF_W-1:0]     timer_low_q, timer_high_q;
  logic [ccsd_pkg::POS_W-1:0]      cycle_pos_q;
  logic [ccsd_pkg::CNT_W-1:0]      edges_q;
  logic [ccsd_pkg::SPEED_W-1:0]    speed_q;
  ccsd_pkg::mode_e                 mode_q;
  logic                            error_q;
  logic [ccsd_pkg::IVL_W-1:0]      interval_q;

  logic                            out_valid_q;
  logic [ccsd_pkg::SPEED_W-1:0]    out_speed_q;
  logic [1:0]                      out_mode_q;
  logic                            out_error_q;
  logic [ccsd_pkg::IVL_W-1:0]      out_value_q;

  logic [ccsd_pkg::IVL_W-1:0]      interval;
  logic [ccsd_pkg::IVL_W-1:0]      divisor;
  logic [ccsd_pkg::HALF_W-1:0]     timer_low_d, timer_high_d;
  logic                            pos_in_range;
  logic                            in_fire;
  logic                            out_free;
  logic                            crank_exec;
  logic                            curve_we;
  logic                            div_start, div_busy, div_done;
  logic [ccsd_pkg::SPEED_W-1:0]    quotient;
  logic [ccsd_pkg::IVL_W-1:0]      rd_data;
  logic [ccsd_pkg::IVL_W-1:0]      value_d;

  assign interval     = {timer_high_q, timer_low_q};
  assign divisor      = (interval == '0) ? ccsd_pkg::IVL_W'(1) : interval;
  assign timer_low_d  = timer_low_q + 1'b1;
  assign timer_high_d = timer_high_q + 1'b1;
  assign pos_in_range = cycle_pos_q < ccsd_pkg::POS_W'(ccsd_pkg::CURVE_DEPTH);
  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign cfg_ready_o  = 1'b1;
  assign crank_exec   = (state_q == ST_EXEC) && (op_q == ccsd_pkg::OP_CRANK);
  assign curve_we     = crank_exec && pos_in_range;
  assign div_start    = crank_exec;

  always_comb begin
    case (op_q)
      ccsd_pkg::OP_CRANK: value_d = interval_q;
      ccsd_pkg::OP_READ:  value_d = rd_hit_q ? rd_data : '0;
      default:            value_d = '0;
    endcase
  end

  ccsd_curve u_curve (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (curve_we),
    .wr_addr_i (ccsd_pkg::CURVE_AW'(cycle_pos_q)),
    .wr_data_i (interval),
    .rd_addr_i (ccsd_pkg::CURVE_AW'(idx_q)),
    .rd_data_o (rd_data)
  );

  ccsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numerator_q),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= ccsd_pkg::OP_TICK;
      idx_q        <= '0;
      rd_hit_q     <= 1'b0;
      numerator_q  <= ccsd_pkg::NUMERATOR_RST;
      threshold_q  <= ccsd_pkg::THRESHOLD_RST;
      sync_cnt_q   <= ccsd_pkg::SYNC_CNT_RST;
      stall_q      <= ccsd_pkg::STALL_RST;
      timer_low_q  <= '0;
      timer_high_q <= '0;
      cycle_pos_q  <= '0;
      edges_q      <= '0;
      speed_q      <= '0;
      mode_q       <= ccsd_pkg::MODE_STOP;
      error_q      <= 1'b0;
      interval_q   <= '0;
      out_valid_q  <= 1'b0;
      out_speed_q  <= '0;
      out_mode_q   <= '0;
      out_error_q  <= 1'b0;
      out_value_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ccsd_pkg::REG_NUMERATOR: numerator_q <= cfg_data_i;
          ccsd_pkg::REG_THRESHOLD: threshold_q <= cfg_data_i;
          ccsd_pkg::REG_SYNC_CNT:  sync_cnt_q  <= cfg_data_i[ccsd_pkg::CNT_W-1:0];
          ccsd_pkg::REG_STALL:     stall_q     <= cfg_data_i[ccsd_pkg::HALF_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            op_q     <= ccsd_pkg::op_e'(op_i);
            idx_q    <= curve_index_i;
            rd_hit_q <= (ccsd_pkg::IDX_W + 9)'(curve_index_i) <
                        (ccsd_pkg::IDX_W + 9)'(ccsd_pkg::CURVE_DEPTH);
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (op_q)
            ccsd_pkg::OP_TICK: begin
              timer_low_q <= timer_low_d;
              if (timer_low_q == '1) begin
                timer_high_q <= timer_high_d;
                if (timer_high_d > stall_q) begin
                  mode_q  <= ccsd_pkg::MODE_STOP;
                  speed_q <= '0;
                end
              end
              state_q <= ST_DONE;
            end
            ccsd_pkg::OP_CRANK: begin
              // curve write (when the position is in range) and divider start happen this cycle
              if (!pos_in_range) begin
                error_q <= 1'b1;
              end
              interval_q   <= interval;
              cycle_pos_q  <= cycle_pos_q + 1'b1;
              edges_q      <= edges_q + 1'b1;
              timer_low_q  <= '0;
              timer_high_q <= '0;
              state_q      <= ST_DIV;
            end
            ccsd_pkg::OP_CAM: begin
              if (edges_q == sync_cnt_q) begin
                cycle_pos_q  <= '0;
                timer_low_q  <= '0;
                timer_high_q <= '0;
              end
              edges_q <= '0;
              state_q <= ST_DONE;
            end
            default: begin
              // curve read issued this cycle, data registered for next
              state_q <= ST_DONE;
            end
          endcase
        end
        ST_DIV: begin
          if (div_done) begin
            speed_q <= quotient;
            mode_q  <= (quotient < threshold_q) ? ccsd_pkg::MODE_CRANK
                                                : ccsd_pkg::MODE_RUN;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_speed_q <= speed_q;
            out_mode_q  <= mode_q;
            out_error_q <= error_q;
            out_value_q <= value_d;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign speed_o         = out_speed_q;
  assign run_mode_o      = out_mode_q;
  assign overrun_error_o = out_error_q;
  assign curve_value_o   = out_value_q;

  `CCSD_ASSERT_IMP(a_div_only_in_div, clk_i, rst_ni, div_busy, state_q == ST_DIV)
  `CCSD_ASSERT_NXT(a_crank_clears_timer, clk_i, rst_ni, crank_exec, interval == '0)
  `CCSD_ASSERT_IMP(a_mode_code, clk_i, rst_ni, out_valid_q, out_mode_q != 2'd3)
  `CCSD_ASSERT_NXT(a_error_sticky, clk_i, rst_ni, error_q, error_q)

endmodule
